@@ design/csd_pkg.sv @@
// ----------------------------------------------------------------------------
// Checksummed sentence decoder package
// Shared types and constants for the sentence decoder and its parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csd_pkg;

   // Parser phase: idle waiting for a dollar, payload, checksum digits,
   // or a fault that is held until the next newline.
   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_PAYLOAD = 2'd1,
      PHASE_CHECK   = 2'd2,
      PHASE_FAULT   = 2'd3
   } phase_type;

   // Status codes of a result item.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EVENT = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   // Event kinds.
   localparam logic [2:0] KIND_CHA = 3'd0;
   localparam logic [2:0] KIND_ACC = 3'd1;
   localparam logic [2:0] KIND_REV = 3'd2;
   localparam logic [2:0] KIND_SHO = 3'd3;
   localparam logic [2:0] KIND_RES = 3'd4;

   localparam int unsigned NUM_KINDS = 5;

   // Sentence type letters, first letter in the high byte, by kind.
   localparam logic [23:0] KIND_LETTERS [NUM_KINDS] = '{
      24'h434841,   // CHA
      24'h414343,   // ACC
      24'h524556,   // REV
      24'h53484F,   // SHO
      24'h524553    // RES
   };

   // Special characters.
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   // Payloads shorter than this many bytes carry a checksum of zero.
   localparam int unsigned MIN_CHECKED_PAYLOAD = 5;

   // One result item.
   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  event_kind;
      logic [16:0] first_value;
      logic [6:0]  second_value;
      logic [6:0]  third_value;
   } result_type;

endpackage

@@ design/csd_parser.sv @@
// ----------------------------------------------------------------------------
// Sentence parser
// Holds the sentence state and, for each accepted byte, updates it and
// works out the result item in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csd_parser #(
   parameter int unsigned MAX_PAYLOAD = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  logic [7:0]           rx_byte,
   output csd_pkg::result_type  result
);
   import csd_pkg::*;

   localparam int unsigned CountWidth = $clog2(MAX_PAYLOAD + 1);

   phase_type              phase_ff, phase_in;
   logic [CountWidth-1:0]  payload_count_ff, payload_count_in;
   logic [7:0]             running_xor_ff, running_xor_in;
   logic [23:0]            type_letters_ff, type_letters_in;
   logic [1:0]             field_number_ff, field_number_in;
   logic [2:0]             digit_count_ff, digit_count_in;
   logic [16:0]            first_field_ff, first_field_in;
   logic [6:0]             second_field_ff, second_field_in;
   logic [6:0]             third_field_ff, third_field_in;
   logic [7:0]             checksum_ff, checksum_in;
   logic [1:0]             checksum_digits_ff, checksum_digits_in;

   // Character decode.
   logic       is_newline, is_dollar, is_star, is_comma, is_digit, is_hex_letter;
   logic       is_hex;
   logic [3:0] digit_value, hex_value;

   assign is_newline    = (rx_byte == CHAR_NEWLINE);
   assign is_dollar     = (rx_byte == CHAR_DOLLAR);
   assign is_star       = (rx_byte == CHAR_STAR);
   assign is_comma      = (rx_byte == CHAR_COMMA);
   assign is_digit      = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign is_hex_letter = (rx_byte >= CHAR_UPPER_A) && (rx_byte <= CHAR_UPPER_F);
   assign is_hex        = is_digit || is_hex_letter;
   assign digit_value   = rx_byte[3:0];
   assign hex_value     = is_hex_letter ? (rx_byte[3:0] + 4'd9) : rx_byte[3:0];

   // Payload checks: the first three bytes form the type, the rest feed the fields.
   logic in_type_zone, payload_full, comma_fault, digit_fault, payload_fault;
   logic digit_taken;
   logic [2:0] digit_limit;

   assign in_type_zone  = (payload_count_ff < CountWidth'(3));
   assign payload_full  = (payload_count_ff >= CountWidth'(MAX_PAYLOAD));
   assign digit_limit   = (field_number_ff == 2'd1) ? 3'd5 : 3'd2;
   assign comma_fault   = !in_type_zone && is_comma && (field_number_ff == 2'd3);
   assign digit_taken   = !in_type_zone && is_digit && (field_number_ff != 2'd0);
   assign digit_fault   = digit_taken && (digit_count_ff >= digit_limit);
   assign payload_fault = is_dollar || payload_full || comma_fault || digit_fault;

   // Checksum digit checks.
   logic check_fault;
   assign check_fault = !is_hex || (checksum_digits_ff >= 2'd2);

   // Sentence completion: checksum comparison and type lookup.
   logic [7:0] expected_sum;
   logic       sum_good, kind_found;
   logic [2:0] kind_index;

   assign expected_sum = (payload_count_ff < CountWidth'(MIN_CHECKED_PAYLOAD)) ?
                         8'd0 : running_xor_ff;
   assign sum_good = (checksum_digits_ff == 2'd2) && (checksum_ff == expected_sum);

   always_comb begin
      kind_found = 1'b0;
      kind_index = KIND_CHA;
      for (int k = 0; k < NUM_KINDS; k++) begin
         if (!kind_found && (type_letters_ff == KIND_LETTERS[k])) begin
            kind_found = 1'b1;
            kind_index = 3'(k);
         end
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (is_newline) begin
         phase_in = PHASE_IDLE;
      end else begin
         unique case (phase_ff)
            PHASE_IDLE: begin
               if (is_dollar) phase_in = PHASE_PAYLOAD;
            end
            PHASE_PAYLOAD: begin
               priority if (is_star)       phase_in = PHASE_CHECK;
               else if (payload_fault)     phase_in = PHASE_FAULT;
               else                        phase_in = PHASE_PAYLOAD;
            end
            PHASE_CHECK: begin
               if (check_fault) phase_in = PHASE_FAULT;
            end
            PHASE_FAULT: phase_in = PHASE_FAULT;
            default:     phase_in = PHASE_IDLE;
         endcase
      end
   end

   // Result item for the current byte.
   always_comb begin
      result = '0;
      result.status = STATUS_OK;
      if (is_newline) begin
         result.status = STATUS_ERROR;
         if ((phase_ff == PHASE_CHECK) && sum_good && kind_found) begin
            result.status      = STATUS_EVENT;
            result.event_kind  = kind_index;
            result.first_value = first_field_ff;
            if ((kind_index == KIND_SHO) || (kind_index == KIND_RES))
               result.second_value = second_field_ff;
            if (kind_index == KIND_RES)
               result.third_value = third_field_ff;
         end
      end else if ((phase_ff == PHASE_PAYLOAD) && !is_star && payload_fault) begin
         result.status = STATUS_ERROR;
      end else if ((phase_ff == PHASE_CHECK) && check_fault) begin
         result.status = STATUS_ERROR;
      end
   end

   // Sentence data update.
   always_comb begin
      payload_count_in   = payload_count_ff;
      running_xor_in     = running_xor_ff;
      type_letters_in    = type_letters_ff;
      field_number_in    = field_number_ff;
      digit_count_in     = digit_count_ff;
      first_field_in     = first_field_ff;
      second_field_in    = second_field_ff;
      third_field_in     = third_field_ff;
      checksum_in        = checksum_ff;
      checksum_digits_in = checksum_digits_ff;

      if (is_newline || ((phase_ff == PHASE_IDLE) && is_dollar)) begin
         // Start from a clean sentence.
         payload_count_in   = '0;
         running_xor_in     = '0;
         type_letters_in    = '0;
         field_number_in    = '0;
         digit_count_in     = '0;
         first_field_in     = '0;
         second_field_in    = '0;
         third_field_in     = '0;
         checksum_in        = '0;
         checksum_digits_in = '0;
      end else if ((phase_ff == PHASE_PAYLOAD) && !is_star && !is_dollar &&
                   !payload_full) begin
         // The byte is stored even when the field parser then faults on it.
         payload_count_in = payload_count_ff + CountWidth'(1);
         running_xor_in   = running_xor_ff ^ rx_byte;
         if (in_type_zone) begin
            type_letters_in = {type_letters_ff[15:0], rx_byte};
         end else if (is_comma) begin
            if (!comma_fault) begin
               field_number_in = field_number_ff + 2'd1;
               digit_count_in  = '0;
            end
         end else if (digit_taken && !digit_fault) begin
            digit_count_in = digit_count_ff + 3'd1;
            unique case (field_number_ff)
               2'd1: first_field_in = {first_field_ff[13:0], 3'b000} +
                                      {first_field_ff[15:0], 1'b0} +
                                      {13'd0, digit_value};
               2'd2: second_field_in = {second_field_ff[3:0], 3'b000} +
                                       {second_field_ff[5:0], 1'b0} +
                                       {3'd0, digit_value};
               2'd3: third_field_in = {third_field_ff[3:0], 3'b000} +
                                      {third_field_ff[5:0], 1'b0} +
                                      {3'd0, digit_value};
               default: ;
            endcase
         end
      end else if ((phase_ff == PHASE_CHECK) && !check_fault) begin
         checksum_in        = {checksum_ff[3:0], hex_value};
         checksum_digits_in = checksum_digits_ff + 2'd1;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PHASE_IDLE;
         payload_count_ff   <= '0;
         running_xor_ff     <= '0;
         type_letters_ff    <= '0;
         field_number_ff    <= '0;
         digit_count_ff     <= '0;
         first_field_ff     <= '0;
         second_field_ff    <= '0;
         third_field_ff     <= '0;
         checksum_ff        <= '0;
         checksum_digits_ff <= '0;
      end else if (byte_valid) begin
         phase_ff           <= phase_in;
         payload_count_ff   <= payload_count_in;
         running_xor_ff     <= running_xor_in;
         type_letters_ff    <= type_letters_in;
         field_number_ff    <= field_number_in;
         digit_count_ff     <= digit_count_in;
         first_field_ff     <= first_field_in;
         second_field_ff    <= second_field_in;
         third_field_ff     <= third_field_in;
         checksum_ff        <= checksum_in;
         checksum_digits_ff <= checksum_digits_in;
      end
   end

   // Checks.
   a_newline_returns_idle: assert property (@(posedge clock) disable iff (reset)
      byte_valid && is_newline |=> (phase_ff == PHASE_IDLE))
      else $error("phase not idle after a newline");

   a_event_only_on_newline: assert property (@(posedge clock) disable iff (reset)
      (result.status == STATUS_EVENT) |-> is_newline && (phase_ff == PHASE_CHECK))
      else $error("event reported outside a checksummed newline");

   a_fault_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_FAULT) && !is_newline |-> (result.status == STATUS_OK))
      else $error("error repeated while a fault is held");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      payload_count_ff <= CountWidth'(MAX_PAYLOAD))
      else $error("payload count beyond its limit");

endmodule

@@ design/checksummed_sentence_decoder.sv @@
// ----------------------------------------------------------------------------
// A result item is registered and is on rsp in the cycle after its byte is taken.
// One byte per cycle unless rsp stalls; the output register reloads as it drains.
// Reset: synchronous, active high; the decoder goes idle, waiting for a dollar.
// Checksummed sentence decoder
// Decodes $payload*HH sentences byte by byte and reports one result item
// per byte: accepted, event ready or error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module checksummed_sentence_decoder #(
   parameter int unsigned MAX_PAYLOAD = 128
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [16:0] first_value, [23:17] second_value,
                                     // [30:24] third_value, [31] zero
   output logic [4:0]  rsp_tuser     // [1:0] status, [4:2] event_kind
);
   import csd_pkg::*;

   logic       req_accept;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   // A new item is taken whenever the output register is empty or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   csd_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_accept),
      .rx_byte    (req_tdata),
      .result     (result)
   );

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept)      rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.third_value, rsp_ff.second_value, rsp_ff.first_value};
   assign rsp_tuser  = {rsp_ff.event_kind, rsp_ff.status};

endmodule

@@ dv/checksummed_sentence_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// Checksummed sentence decoder checker
// Watches both streams of the decoder, works out the result item that each
// accepted byte should give and compares it, field by field, with the result
// items that the decoder hands out, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module checksummed_sentence_decoder_checker #(
   parameter int unsigned MAX_PAYLOAD = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // [16:0] first_value, [23:17] second_value,
                                     // [30:24] third_value, [31] zero
   input  logic [4:0]  rsp_tuser,    // [1:0] status, [4:2] event_kind
   output int          mismatch_count,
   output int          results_pending,
   output int          results_checked,
   output int          events_seen,
   output int          errors_seen
);
   import csd_pkg::*;

   // Decoder state as the predictor sees it.
   phase_type   phase;
   logic [7:0]  byte_count;
   logic [7:0]  xor_sum;
   logic [23:0] type_word;
   logic [1:0]  field_index;
   logic [2:0]  digits_in_field;
   logic [16:0] field_value [3];
   logic [7:0]  sum_received;
   logic [1:0]  sum_digits;

   // Result items still owed by the decoder, oldest first.
   result_type  owed_results [$];

   int fail_tally    = 0;
   int checked_tally = 0;
   int event_tally   = 0;
   int error_tally   = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: result item %0d: %s", $time, checked_tally, msg);
      fail_tally++;
   endtask

   // Forget everything about the sentence in progress.
   function automatic void start_sentence();
      byte_count      = '0;
      xor_sum         = '0;
      type_word       = '0;
      field_index     = '0;
      digits_in_field = '0;
      field_value     = '{default: '0};
      sum_received    = '0;
      sum_digits      = '0;
   endfunction

   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE)
         return int'(c - CHAR_ZERO);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
         return int'(c - CHAR_UPPER_A) + 10;
      return -1;
   endfunction

   // Store one payload byte; a zero return means the byte is a fault.
   function automatic bit store_payload_byte(input logic [7:0] c);
      logic [7:0]  pos;
      int unsigned slot;
      if (byte_count >= MAX_PAYLOAD)
         return 1'b0;
      pos        = byte_count;
      byte_count = byte_count + 8'd1;
      xor_sum    = xor_sum ^ c;
      // The first three bytes name the sentence type.
      if (pos < 3) begin
         type_word = {type_word[15:0], c};
         return 1'b1;
      end
      if (c == CHAR_COMMA) begin
         if (field_index >= 3)
            return 1'b0;
         field_index++;
         digits_in_field = '0;
         return 1'b1;
      end
      // Digits count only once a field is open.
      if (c >= CHAR_ZERO && c <= CHAR_NINE && field_index != 0) begin
         slot = field_index - 1;
         if (digits_in_field >= ((slot == 0) ? 5 : 2))
            return 1'b0;
         digits_in_field++;
         field_value[slot] = 17'(field_value[slot] * 10 + (c - CHAR_ZERO));
      end
      return 1'b1;
   endfunction

   // Work out the result item of one received byte and move the state on.
   function automatic result_type decode_byte(input logic [7:0] c);
      result_type  res;
      logic [7:0]  sum_wanted;
      int          nibble;
      res        = '0;
      res.status = STATUS_OK;

      // A newline always ends the sentence, well formed or not.
      if (c == CHAR_NEWLINE) begin
         res.status = STATUS_ERROR;
         sum_wanted = (byte_count < MIN_CHECKED_PAYLOAD) ? 8'd0 : xor_sum;
         if (phase == PHASE_CHECK && sum_digits == 2 && sum_received == sum_wanted) begin
            for (int k = 0; k < NUM_KINDS; k++) begin
               if (type_word == KIND_LETTERS[k]) begin
                  res.status       = STATUS_EVENT;
                  res.event_kind   = 3'(k);
                  res.first_value  = field_value[0];
                  res.second_value = (3'(k) >= KIND_SHO) ? field_value[1][6:0] : 7'd0;
                  res.third_value  = (3'(k) == KIND_RES) ? field_value[2][6:0] : 7'd0;
               end
            end
         end
         phase = PHASE_IDLE;
         start_sentence();
         return res;
      end

      case (phase)
         PHASE_IDLE: begin
            if (c == CHAR_DOLLAR) begin
               start_sentence();
               phase = PHASE_PAYLOAD;
            end
         end
         PHASE_PAYLOAD: begin
            if (c == CHAR_STAR) begin
               phase = PHASE_CHECK;
            end else if (c == CHAR_DOLLAR || !store_payload_byte(c)) begin
               phase      = PHASE_FAULT;
               res.status = STATUS_ERROR;
            end
         end
         PHASE_CHECK: begin
            nibble = hex_digit_value(c);
            if (nibble < 0 || sum_digits >= 2) begin
               phase      = PHASE_FAULT;
               res.status = STATUS_ERROR;
            end else begin
               sum_received = {sum_received[3:0], 4'(nibble)};
               sum_digits++;
            end
         end
         default: begin
            // A fault stays quiet until the newline.
         end
      endcase
      return res;
   endfunction

   // Predict on every accepted byte and compare on every accepted result item.
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         owed_results.delete();
         phase = PHASE_IDLE;
         start_sentence();
      end else begin
         if (req_tvalid && req_tready)
            owed_results.push_back(decode_byte(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               report_mismatch($sformatf("arrived with no expectation, status %0d",
                                         rsp_tuser[1:0]));
            end else begin
               want = owed_results.pop_front();
               if (rsp_tuser[1:0] != want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tuser[1:0], want.status));
               if (rsp_tuser[4:2] != want.event_kind)
                  report_mismatch($sformatf("event_kind %0d, expected %0d",
                                            rsp_tuser[4:2], want.event_kind));
               if (rsp_tdata[16:0] != want.first_value)
                  report_mismatch($sformatf("first_value %0d, expected %0d",
                                            rsp_tdata[16:0], want.first_value));
               if (rsp_tdata[23:17] != want.second_value)
                  report_mismatch($sformatf("second_value %0d, expected %0d",
                                            rsp_tdata[23:17], want.second_value));
               if (rsp_tdata[30:24] != want.third_value)
                  report_mismatch($sformatf("third_value %0d, expected %0d",
                                            rsp_tdata[30:24], want.third_value));
               if (want.status == STATUS_EVENT)
                  event_tally++;
               if (want.status == STATUS_ERROR)
                  error_tally++;
               checked_tally++;
            end
         end
      end
      mismatch_count  <= fail_tally;
      results_pending <= owed_results.size();
      results_checked <= checked_tally;
      events_seen     <= event_tally;
      errors_seen     <= error_tally;
   end

endmodule

@@ dv/checksummed_sentence_decoder_test.sv @@
// ----------------------------------------------------------------------------
// Checksummed sentence decoder testbench
// Feeds the decoder directed sentences for each kind, the field extremes and
// every way a sentence can go wrong, then random sentences, broken sentences
// and line noise, with random idling on both streams, a long output stall
// and a drain pause. The checker beside the decoder does all the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module checksummed_sentence_decoder_test;
   import csd_pkg::*;

   localparam int unsigned MAX_PAYLOAD  = 128;
   localparam int unsigned RANDOM_BYTES = 860;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned LONG_STALL   = 150;
   localparam int unsigned IDLE_PERCENT = 33;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_FILL    = 8'h78;

   // Ways of spoiling the framing of a sentence.
   typedef enum int unsigned {
      FLAW_NONE,
      FLAW_BAD_SUM,
      FLAW_LOWER_HEX,
      FLAW_ONE_DIGIT,
      FLAW_THREE_DIGITS,
      FLAW_NO_STAR,
      FLAW_STRAY_DOLLAR
   } flaw_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [4:0]  rsp_tuser;

   int mismatch_count;
   int results_pending;
   int results_checked;
   int events_seen;
   int errors_seen;

   logic [7:0]  line_bytes [$];
   bit          idling_on     = 1'b1;
   bit          stall_request = 1'b0;
   int unsigned bytes_sent    = 0;
   int unsigned cycle_count   = 0;

   checksummed_sentence_decoder #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   checksummed_sentence_decoder_checker #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .results_checked (results_checked),
      .events_seen     (events_seen),
      .errors_seen     (errors_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one byte, perhaps after a random gap, and wait until it is taken.
   task automatic send_byte(input logic [7:0] c);
      if (idling_on) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_line();
      foreach (line_bytes[i])
         send_byte(line_bytes[i]);
      line_bytes.delete();
   endtask

   // Stop offering and wait until every owed result item has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      return (nibble < 4'd10) ? CHAR_ZERO + 8'(nibble)
                              : CHAR_UPPER_A + 8'(nibble) - 8'd10;
   endfunction

   // Any byte that neither opens, closes nor ends the payload.
   function automatic logic [7:0] payload_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == CHAR_DOLLAR || c == CHAR_STAR || c == CHAR_NEWLINE);
      return c;
   endfunction

   // Wrap a payload into a whole sentence, spoiled as the flaw says.
   task automatic frame_body(input logic [7:0] body [$], input flaw_type flaw);
      logic [7:0] sum;
      logic [7:0] low_char;
      sum = '0;
      foreach (body[i])
         sum ^= body[i];
      if (body.size() < MIN_CHECKED_PAYLOAD)
         sum = '0;
      if (flaw == FLAW_BAD_SUM)
         sum ^= 8'($urandom_range(1, 255));
      if (flaw == FLAW_STRAY_DOLLAR)
         body.insert($urandom_range(body.size()), CHAR_DOLLAR);
      line_bytes.push_back(CHAR_DOLLAR);
      foreach (body[i])
         line_bytes.push_back(body[i]);
      if (flaw != FLAW_NO_STAR) begin
         line_bytes.push_back(CHAR_STAR);
         line_bytes.push_back(hex_char(sum[7:4]));
         low_char = hex_char(sum[3:0]);
         if (flaw == FLAW_LOWER_HEX)
            low_char = CHAR_LOWER_A + 8'($urandom_range(5));
         if (flaw != FLAW_ONE_DIGIT)
            line_bytes.push_back(low_char);
         if (flaw == FLAW_THREE_DIGITS)
            line_bytes.push_back(hex_char(4'($urandom_range(15))));
      end
      // A fault is held, so trailing rubbish must be ignored until the newline.
      if (flaw != FLAW_NONE && flaw != FLAW_BAD_SUM)
         repeat ($urandom_range(3))
            line_bytes.push_back(payload_char());
      line_bytes.push_back(CHAR_NEWLINE);
   endtask

   task automatic put_sentence(input string payload, input flaw_type flaw);
      logic [7:0] body [$];
      for (int i = 0; i < payload.len(); i++)
         body.push_back(8'(payload[i]));
      frame_body(body, flaw);
   endtask

   task automatic put_text(input string text);
      for (int i = 0; i < text.len(); i++)
         line_bytes.push_back(8'(text[i]));
   endtask

   // One random line: mostly well-formed sentences with random content, the
   // rest line noise, odd lengths and broken framing.
   task automatic make_random_line();
      logic [7:0]  body [$];
      int unsigned shape;
      int unsigned pick;
      int unsigned kind;
      int unsigned fields;
      int unsigned limit;
      int unsigned ndig;
      int unsigned target;
      flaw_type    flaw;
      shape = $urandom_range(99);

      // Line noise, ended by a newline so that the next sentence starts clean.
      if (shape < 6) begin
         repeat ($urandom_range(1, 5))
            line_bytes.push_back(8'($urandom_range(255)));
         line_bytes.push_back(CHAR_NEWLINE);
         return;
      end

      // Type letters, nearly always a known kind.
      if ($urandom_range(9) != 0) begin
         kind = $urandom_range(NUM_KINDS - 1);
         for (int i = 2; i >= 0; i--)
            body.push_back(KIND_LETTERS[kind][8*i +: 8]);
      end else begin
         repeat (3)
            body.push_back(payload_char());
      end

      // Digits or rubbish before the first comma are ignored by the parser.
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 3))
            body.push_back(($urandom_range(1) != 0) ? CHAR_ZERO + 8'($urandom_range(9))
                                                     : payload_char());

      fields = $urandom_range(3);
      if ($urandom_range(19) == 0)
         fields = 4;
      for (int f = 0; f < fields; f++) begin
         body.push_back(CHAR_COMMA);
         limit = (f == 0) ? 5 : 2;
         ndig  = $urandom_range(limit);
         if ($urandom_range(24) == 0)
            ndig = limit + 1;
         repeat (ndig)
            body.push_back(CHAR_ZERO + 8'($urandom_range(9)));
         if ($urandom_range(9) == 0)
            body.push_back(payload_char());
      end

      // A few payloads right at the length limit, a few very short ones.
      if (shape < 9) begin
         target = MAX_PAYLOAD - 1 + $urandom_range(2);
         while (body.size() < target)
            body.push_back(payload_char());
      end else if (shape < 16) begin
         target = $urandom_range(4);
         while (body.size() > target)
            void'(body.pop_back());
      end

      pick = $urandom_range(99);
      if (pick < 70)
         flaw = FLAW_NONE;
      else if (pick < 80)
         flaw = FLAW_BAD_SUM;
      else if (pick < 84)
         flaw = FLAW_LOWER_HEX;
      else if (pick < 88)
         flaw = FLAW_ONE_DIGIT;
      else if (pick < 92)
         flaw = FLAW_THREE_DIGITS;
      else if (pick < 96)
         flaw = FLAW_NO_STAR;
      else
         flaw = FLAW_STRAY_DOLLAR;
      frame_body(body, flaw);
   endtask

   // Output side: random stalls, with a long hold-off on request.
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = LONG_STALL;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (idling_on) begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Give up if the run takes far longer than it ever should.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d result items owed.",
               cycle_count, results_pending);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [7:0]  body [$];
      int unsigned directed_bytes;
      int unsigned line_count;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: every kind and the field extremes.
      put_sentence("CHA,99999", FLAW_NONE);
      put_sentence("ACC,0", FLAW_NONE);
      put_sentence("REV,54321", FLAW_NONE);
      put_sentence("SHO,12,99", FLAW_NONE);
      put_sentence("RES,99999,99,99", FLAW_NONE);
      put_sentence("RES,7,,3", FLAW_NONE);
      // Short payloads carry a zero checksum; an unknown type is an error.
      put_sentence("CHA", FLAW_NONE);
      put_sentence("", FLAW_NONE);
      put_sentence("XYZ,5", FLAW_NONE);
      put_sentence("CHA12,34", FLAW_NONE);
      // Broken checksums and framing.
      put_sentence("ACC,1", FLAW_BAD_SUM);
      put_sentence("REV,2", FLAW_LOWER_HEX);
      put_sentence("SHO,3,4", FLAW_ONE_DIGIT);
      put_sentence("RES,1,2,3", FLAW_THREE_DIGITS);
      put_sentence("CHA,5", FLAW_NO_STAR);
      put_sentence("ACC,6", FLAW_STRAY_DOLLAR);
      put_text("$CHA*1$\n");
      put_text("$CHA*G0\n");
      // Too many digits in each field, and one field too many.
      put_sentence("CHA,123456", FLAW_NONE);
      put_sentence("SHO,1,234", FLAW_NONE);
      put_sentence("RES,1,2,345", FLAW_NONE);
      put_sentence("RES,1,2,3,4", FLAW_NONE);
      // A payload of exactly the limit, then one byte too long.
      for (int i = 2; i >= 0; i--)
         body.push_back(KIND_LETTERS[KIND_CHA][8*i +: 8]);
      while (body.size() < MAX_PAYLOAD)
         body.push_back(CHAR_FILL);
      frame_body(body, FLAW_NONE);
      body.push_back(CHAR_FILL);
      frame_body(body, FLAW_NONE);
      // Bytes between sentences, and a newline while idle.
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      line_bytes.push_back(CHAR_NEWLINE);
      send_line();
      directed_bytes = bytes_sent;

      // Random part, with a stretch of no idling, a long output stall while
      // bytes keep coming, and one pause until everything has drained.
      line_count = 0;
      while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
         line_count++;
         idling_on = !(line_count >= 20 && line_count < 35);
         if (line_count == 45)
            stall_request = 1'b1;
         if (line_count == 60)
            wait_for_drain();
         make_random_line();
         send_line();
      end

      wait_for_drain();
      repeat (4) @(posedge clock);

      $display("Sent %0d bytes: directed sentences, then %0d random lines with noise,",
               bytes_sent, line_count);
      $display("broken framing, idling and stalls; %0d items checked, %0d events, %0d errors.",
               results_checked, events_seen, errors_seen);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
